### sv/bhde_pkg.sv
// bhde_pkg: shared types and constants of the breadth-first hop distance engine
// used by the lane, merge, top level and checker files; no dependencies
`default_nettype none

package bhde_pkg;

  // fixed field widths
  localparam int IDX_W     = 5;
  localparam int ROW_W     = 32;
  localparam int DIST_W    = 5;
  localparam int CFG_W     = 6;
  localparam int ROW_DEPTH = 32;

  // stream packing
  localparam int IN_W      = 48;
  localparam int OUT_W     = 16;
  localparam int OUT_USED  = 2 * IDX_W + 1;

  localparam logic [DIST_W-1:0] DIST_MAX       = 5'd31;
  localparam logic [CFG_W-1:0]  NODE_COUNT_RST = 6'd32;

  // item kinds carried in tuser
  localparam logic OP_WRITE_ROW = 1'b0;
  localparam logic OP_QUERY     = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } state_t;

  // broadcast from the sequencer to every lane
  typedef struct packed {
    logic              start;
    logic              apply;
    logic              swap;
    logic [DIST_W-1:0] dist_in;
  } lane_ctrl_t;

  // frontier status from the merge stage
  typedef struct packed {
    logic any_cur;
    logic any_next;
  } merge_stat_t;

endpackage

`default_nettype wire

### sv/bhde_lane.sv
// bhde_lane: per-node lane holding visited, frontier bits and hop distance
// depends on bhde_pkg
`default_nettype none

module bhde_lane (
  input  logic                     clk,
  input  logic                     rst,
  input  bhde_pkg::lane_ctrl_t     ctrl,
  input  logic                     is_src,
  input  logic                     keep,
  input  logic                     edge_bit,
  input  logic                     pick,
  output logic                     visited,
  output logic                     cur_f,
  output logic                     next_f,
  output logic [bhde_pkg::DIST_W-1:0] hop_dist
);
  import bhde_pkg::*;

  logic fresh;

  // node newly reached by the row being applied
  assign fresh = ctrl.apply & edge_bit & keep & ~visited;

  // visited and frontier bits
  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= 1'b0;
      cur_f   <= 1'b0;
      next_f  <= 1'b0;
    end else if (ctrl.start) begin
      visited <= is_src;
      cur_f   <= is_src;
      next_f  <= 1'b0;
    end else begin
      if (fresh) begin
        visited <= 1'b1;
        next_f  <= 1'b1;
      end
      if (pick) begin
        cur_f <= 1'b0;
      end
      if (ctrl.swap) begin
        cur_f  <= next_f;
        next_f <= 1'b0;
      end
    end
  end

  // hop distance: zero for the source at query start, else written on first visit
  always_ff @(posedge clk) begin
    if (ctrl.start && is_src) begin
      hop_dist <= '0;
    end else if (fresh) begin
      hop_dist <= ctrl.dist_in;
    end
  end

endmodule

`default_nettype wire

### sv/bhde_merge.sv
// bhde_merge: combines lane frontier bits, picks the next node to expand
// depends on bhde_pkg
`default_nettype none

module bhde_merge #(
  parameter int MAX_NODES = 32,
  localparam int NODE_W   = $clog2(MAX_NODES)
) (
  input  logic [MAX_NODES-1:0]   cur_vec,
  input  logic [MAX_NODES-1:0]   next_vec,
  output logic [MAX_NODES-1:0]   pick_vec,
  output logic [NODE_W-1:0]      pick_idx,
  output bhde_pkg::merge_stat_t  stat
);
  import bhde_pkg::*;

  logic found;

  // lowest set frontier bit as one-hot
  assign pick_vec = cur_vec & (~cur_vec + MAX_NODES'(1));

  // lowest set frontier bit as index
  always_comb begin
    pick_idx = '0;
    found    = 1'b0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (cur_vec[i] && !found) begin
        pick_idx = NODE_W'(i);
        found    = 1'b1;
      end
    end
  end

  // frontier occupancy
  assign stat.any_cur  = |cur_vec;
  assign stat.any_next = |next_vec;

endmodule

`default_nettype wire

### sv/bfs_hop_distance_engine_top.sv
// bfs_hop_distance_engine_top: BFS hop distances over a stored adjacency matrix
// row write: accepted while idle, ready again the next cycle
// query: search reads one adjacency row per reached node, source included, from the single
//   read port; then one result per active node per cycle unless m_tready stalls the output
// reset (rst, synchronous): idle, no results pending, node_count = 32
`default_nettype none

module bfs_hop_distance_engine_top #(
  parameter int MAX_NODES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: row_index[4:0], row_bits[36:5], source[41:37], zero fill
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bhde_pkg::IN_W-1:0]     s_tdata,
  // s_tuser: opcode[0]
  input  logic                          s_tuser,
  // m_tdata: target[4:0], distance[9:5], reachable[10], zero fill
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bhde_pkg::OUT_W-1:0]    m_tdata,
  output logic                          m_tlast,
  // node_count register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bhde_pkg::CFG_W-1:0]    cfg_data
);
  import bhde_pkg::*;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int ROWS   = (MAX_NODES < ROW_DEPTH) ? MAX_NODES : ROW_DEPTH;
  localparam int ROW_AW = $clog2(ROWS);

  state_t state, state_next;

  logic [CFG_W-1:0]   node_count;
  logic [CNT_W-1:0]   n_eff, n_q, n_keep, cnt;
  logic [CMP_W-1:0]   ncfg;
  logic [DIST_W-1:0]  level, level_inc;
  logic               pending;
  logic [ROW_W-1:0]   rd_row;
  logic [ROW_W-1:0]   adj_mem [ROWS];

  logic [IDX_W-1:0]   row_index, source;
  logic [ROW_W-1:0]   row_bits;

  logic               in_xfer, q_start, wr_en, pick_go, swap, search_done, load;
  logic               last_item;

  logic [MAX_NODES-1:0] keep, src_hit, lane_edge, lane_pick;
  logic [MAX_NODES-1:0] visited_vec, cur_vec, next_vec, pick_vec;
  logic [DIST_W-1:0]    lane_dist [MAX_NODES];
  logic [NODE_W-1:0]    pick_idx, emit_idx;
  merge_stat_t          stat;
  lane_ctrl_t           ctrl;

  // input field unpacking
  assign row_index = s_tdata[IDX_W-1:0];
  assign row_bits  = s_tdata[IDX_W+ROW_W-1:IDX_W];
  assign source    = s_tdata[2*IDX_W+ROW_W-1:IDX_W+ROW_W];

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = s_tvalid && s_tready;
  assign q_start   = in_xfer && (s_tuser == OP_QUERY);
  assign wr_en     = in_xfer && (s_tuser == OP_WRITE_ROW) && (32'(row_index) < 32'(ROWS));

  // node_count register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      node_count <= cfg_data;
    end
  end

  // active node count, clamped to 1 .. MAX_NODES
  always_comb begin
    ncfg = CMP_W'(node_count);
    if (ncfg == '0) begin
      n_eff = CNT_W'(1);
    end else if (ncfg > CMP_W'(MAX_NODES)) begin
      n_eff = CNT_W'(MAX_NODES);
    end else begin
      n_eff = CNT_W'(ncfg);
    end
  end

  assign n_keep = (state == ST_IDLE) ? n_eff : n_q;

  // adjacency memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      adj_mem[row_index[ROW_AW-1:0]] <= row_bits;
    end
    if (pick_go) begin
      rd_row <= adj_mem[pick_idx[ROW_AW-1:0]];
    end
  end

  // search control
  assign pick_go     = (state == ST_SEARCH) && stat.any_cur;
  assign swap        = (state == ST_SEARCH) && !stat.any_cur && !pending && stat.any_next;
  assign search_done = (state == ST_SEARCH) && !stat.any_cur && !pending && !stat.any_next;
  assign load        = (state == ST_EMIT) && (!m_tvalid || m_tready);
  assign last_item   = (cnt == n_q - CNT_W'(1));
  assign level_inc   = (level == DIST_MAX) ? DIST_MAX : level + DIST_W'(1);

  assign ctrl.start   = q_start;
  assign ctrl.apply   = pending;
  assign ctrl.swap    = swap;
  assign ctrl.dist_in = level_inc;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_start) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (search_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (load && last_item) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // read pipeline, level, result counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      level   <= '0;
      n_q     <= CNT_W'(1);
      cnt     <= '0;
    end else begin
      pending <= pick_go;
      if (q_start) begin
        level <= '0;
        n_q   <= n_eff;
        cnt   <= '0;
      end else begin
        if (swap) level <= level_inc;
        if (load) cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // lanes, one per node
  for (genvar j = 0; j < MAX_NODES; j++) begin : g_lane
    assign keep[j]      = (32'(j) < 32'(n_keep));
    assign src_hit[j]   = keep[j] && (32'(source) == 32'(j));
    assign lane_pick[j] = pick_go && pick_vec[j];
    if (j < ROW_W) begin : g_edge
      assign lane_edge[j] = rd_row[j];
    end else begin : g_noedge
      assign lane_edge[j] = 1'b0;
    end

    bhde_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .is_src   (src_hit[j]),
      .keep     (keep[j]),
      .edge_bit (lane_edge[j]),
      .pick     (lane_pick[j]),
      .visited  (visited_vec[j]),
      .cur_f    (cur_vec[j]),
      .next_f   (next_vec[j]),
      .hop_dist (lane_dist[j])
    );
  end

  bhde_merge #(
    .MAX_NODES (MAX_NODES)
  ) u_merge (
    .cur_vec  (cur_vec),
    .next_vec (next_vec),
    .pick_vec (pick_vec),
    .pick_idx (pick_idx),
    .stat     (stat)
  );

  assign emit_idx = cnt[NODE_W-1:0];

  // result output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {(OUT_W - OUT_USED)'(0),
                  visited_vec[emit_idx],
                  visited_vec[emit_idx] ? lane_dist[emit_idx] : DIST_W'(0),
                  IDX_W'(cnt)};
      m_tlast <= last_item;
    end
  end

endmodule

`default_nettype wire

### sv/bhde_checker.sv
// bhde_checker: port-level assertions for bfs_hop_distance_engine_top, bound below
// depends on bhde_pkg
`default_nettype none

module bhde_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       s_tuser,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [bhde_pkg::OUT_W-1:0] m_tdata,
  input logic                       m_tlast
);
  import bhde_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // a row write leaves the block ready in the next cycle
  a_write_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_WRITE_ROW) |=> s_tready)
    else $error("not ready after row write");

  // a query transfer makes the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_QUERY) |=> !s_tready)
    else $error("ready right after query");

  // unreachable target reports zero distance
  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[10] |-> (m_tdata[9:5] == 5'd0))
    else $error("unreachable result with nonzero distance");

endmodule

bind bfs_hop_distance_engine_top bhde_checker u_bhde_checker (.*);

`default_nettype wire
